FILE: hw/rtl/associated_legendre_eval_assert.svh
// Assertion macros for the associated Legendre evaluator.
// Used by the top level only; no other dependencies.
`ifndef ASSOCIATED_LEGENDRE_EVAL_ASSERT_SVH
`define ASSOCIATED_LEGENDRE_EVAL_ASSERT_SVH
// implication checked on every edge outside reset
`define ALE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ALE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: hw/rtl/ale_pkg.sv
// Package for the associated Legendre evaluator: sequencer states
// and status codes. No dependencies.
package ale_pkg;
  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_SQRT, ST_SEED_INT, ST_SEED_S, ST_P1_INT, ST_P1_X,
    ST_T_INT, ST_T_X, ST_U_INT, ST_SUB, ST_DIV, ST_OUT
  } state_t;

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_BAD = 2'd1;
  localparam logic [1:0] STAT_SAT = 2'd2;
endpackage

FILE: hw/rtl/associated_legendre_eval.sv
// Associated Legendre evaluator P_l^m(x), Q2.30 in, Q32.32 out.
// A bad argument goes straight from CHECK to OUT. Each recurrence step is three
// multiplies, a subtract and a 64-step restoring divide with a final rounding step.
// A new item is taken only in IDLE, which follows OUT once the output register is free.
// rst_n (synchronous, active low) clears the sequencer, the configuration registers and the output valid.
module associated_legendre_eval
  import ale_pkg::*;
#(
  parameter int MAX_DEGREE = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] x_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] result_value
  output logic [1:0]  out_tuser   // [1:0] status
);
`include "associated_legendre_eval_assert.svh"

  localparam logic [63:0] LIM_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIM_NEG = 64'h8000_0000_0000_0000;

  state_t state_r, state_nxt;
  logic [3:0]  degree_r;
  logic signed [4:0] order_r;
  logic signed [31:0] x_r;
  logic [31:0] xm_r;
  logic [63:0] sv_r;      // sqrt remainder / divide remainder
  logic [63:0] sres_r;    // sqrt result
  logic [63:0] sbit_r;
  logic [31:0] s_r;
  logic signed [63:0] pmm_r, pm1_r, acc_r, u_r;
  logic [4:0]  i_r;       // loop index
  logic [6:0]  cnt_r;
  logic        sat_r;
  logic [63:0] qmag_r;    // divide quotient / dividend shift
  logic        qneg_r;
  logic [63:0] res_r;
  logic [1:0]  stat_r;
  logic [1:0]  ostat_r;
  logic        ovalid_r;

  // Combinational helper functions.
  function automatic logic [63:0] mag(input logic signed [63:0] v);
    mag = v[63] ? (64'd0 - v) : v;
  endfunction

  // clamp magnitude to signed range; returns {sat, value}
  function automatic logic [64:0] mksigned(input logic neg, input logic [63:0] m);
    logic [63:0] lim;
    logic [63:0] mm;
    logic s;
    lim = neg ? LIM_NEG : LIM_POS;
    s = m > lim;
    mm = s ? lim : m;
    mksigned = {s, neg ? (64'd0 - mm) : mm};
  endfunction

  // one multiplier path: a times small int or Q.30 magnitude
  logic signed [63:0] mul_a;
  logic [31:0]        mul_b;
  logic               mul_bneg, mul_q30;
  logic [63:0]        am;
  logic [63:0]        hi, lo;
  logic [63:0]        lo_raw;
  logic [95:0]        prod_int;
  logic [63:0]        mres_m;
  logic [64:0]        mres;

  always_comb begin
    am = mag(mul_a);
    hi = {32'd0, am[63:32]} * {32'd0, mul_b};
    lo_raw = {32'd0, am[31:0]} * {32'd0, mul_b};
    lo = (lo_raw + 64'd536870912) >> 30;
    prod_int = {hi, 32'd0} + {32'd0, lo_raw};
    if (mul_q30) begin
      mres_m = (hi > 64'h2000_0000_0000_0000) ? 64'hFFFF_FFFF_FFFF_FFFF
             : ((hi << 2) + lo);
    end else begin
      mres_m = (prod_int[95:64] != 32'd0) ? 64'hFFFF_FFFF_FFFF_FFFF
             : prod_int[63:0];
    end
    mres = mksigned(mul_a[63] ^ mul_bneg, mres_m);
  end

  logic [4:0] twoim1;
  logic [4:0] ipm1;
  logic [4:0] lm;
  logic [64:0] subr;
  logic [64:0] sq_try;
  logic [63:0] sq_res_nxt;
  logic [63:0] div_k;
  logic [64:0] div_try;
  logic [63:0] div_rem_sh;

  always_comb begin
    twoim1 = {i_r[3:0], 1'b0} - 5'd1;
    ipm1 = i_r + order_r - 5'd1;
    lm = i_r - order_r;
    mul_a = acc_r;
    mul_b = 32'd0;
    mul_bneg = 1'b0;
    mul_q30 = 1'b0;
    case (state_r)
      ST_CHECK:    begin mul_a = {32'd0, xm_r}; mul_b = xm_r; end
      ST_SEED_INT: begin mul_a = pmm_r; mul_b = {27'd0, twoim1}; mul_bneg = 1'b1; end
      ST_SEED_S:   begin mul_a = acc_r; mul_b = s_r; mul_q30 = 1'b1; end
      ST_P1_INT:   begin mul_a = pmm_r; mul_b = {27'd0, twoim1}; end
      ST_P1_X:     begin mul_a = acc_r; mul_b = xm_r; mul_bneg = x_r[31]; mul_q30 = 1'b1; end
      ST_T_INT:    begin mul_a = pm1_r; mul_b = {27'd0, twoim1}; end
      ST_T_X:      begin mul_a = acc_r; mul_b = xm_r; mul_bneg = x_r[31]; mul_q30 = 1'b1; end
      ST_U_INT:    begin mul_a = pmm_r; mul_b = {27'd0, ipm1}; end
      default: ;
    endcase
    sq_try = {1'b0, sv_r} - {1'b0, sres_r + sbit_r};
    sq_res_nxt = (!sq_try[64]) ? ((sres_r >> 1) + sbit_r) : (sres_r >> 1);
    // saturating a - b
    subr = {1'b0, acc_r - u_r};
    if (!u_r[63] && acc_r[63] == 1'b0) subr = {1'b0, acc_r - u_r};
    if (u_r[63] && !acc_r[63] && (acc_r - u_r) >= LIM_NEG)
      subr = {1'b1, LIM_POS};
    else if (!u_r[63] && u_r != 64'd0 && acc_r[63] && (acc_r - u_r) < LIM_NEG)
      subr = {1'b1, LIM_NEG};
    div_k = {59'd0, lm};
    div_rem_sh = {sv_r[62:0], qmag_r[63]};
    div_try = {sv_r[63], div_rem_sh} - {1'b0, div_k};
  end

  // ---- sequencer ------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  logic in_fire;
  assign in_fire = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (order_r[4] || $signed({1'b0, degree_r}) < order_r
            || {28'd0, degree_r} > MAX_DEGREE[31:0]
            || x_r > 32'sh4000_0000 || x_r < -32'sh4000_0000)
          state_nxt = ST_OUT;
        else if (order_r != 5'sd0) state_nxt = ST_SQRT;
        else if ({1'b0, degree_r} > order_r) state_nxt = ST_P1_INT;
        else state_nxt = ST_OUT;
      end
      ST_SQRT:     if (cnt_r == 7'd31) state_nxt = ST_SEED_INT;
      ST_SEED_INT: state_nxt = ST_SEED_S;
      ST_SEED_S: begin
        if (i_r != order_r) state_nxt = ST_SEED_INT;
        else if ({1'b0, degree_r} > order_r) state_nxt = ST_P1_INT;
        else state_nxt = ST_OUT;
      end
      ST_P1_INT: state_nxt = ST_P1_X;
      ST_P1_X:   state_nxt = ({1'b0, degree_r} > order_r + 5'sd1) ? ST_T_INT : ST_OUT;
      ST_T_INT:  state_nxt = ST_T_X;
      ST_T_X:    state_nxt = ST_U_INT;
      ST_U_INT:  state_nxt = ST_SUB;
      ST_SUB:    state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == 7'd64)
          state_nxt = (i_r == {1'b0, degree_r}) ? ST_OUT : ST_T_INT;
      end
      // hold while the previous item still sits in the output register
      ST_OUT:  if (!ovalid_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  logic [64:0] dres;
  logic [63:0] qrnd;
  always_comb begin
    // quotient magnitude rounded half up (half away from zero) on final step via remainder test
    qrnd = qmag_r + (({sv_r[62:0], 1'b0} >= div_k) ? 64'd1 : 64'd0);
    dres = mksigned(qneg_r, qrnd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= 4'd0;
      order_r  <= 5'sd0;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == 1'b0) degree_r <= cfg_wdata[3:0];
        else order_r <= cfg_wdata;
      end
      if (state_r == ST_OUT && (!ovalid_r || out_tready)) ovalid_r <= 1'b1;
      else if (out_tvalid && out_tready) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: if (in_fire) begin
        x_r  <= in_tdata;
        xm_r <= in_tdata[31] ? (32'd0 - in_tdata) : in_tdata;
        sat_r <= 1'b0;
        stat_r <= STAT_OK;
      end
      ST_CHECK: begin
        sv_r   <= 64'h1000_0000_0000_0000 - lo_raw;
        sres_r <= 64'd0;
        sbit_r <= 64'h4000_0000_0000_0000;
        cnt_r  <= 7'd0;
        pmm_r  <= 64'sh1_0000_0000;
        acc_r  <= 64'sh1_0000_0000;
        i_r    <= 5'd1;
        if (state_nxt == ST_OUT && (order_r[4] || $signed({1'b0, degree_r}) < order_r
            || {28'd0, degree_r} > MAX_DEGREE[31:0]
            || x_r > 32'sh4000_0000 || x_r < -32'sh4000_0000))
          stat_r <= STAT_BAD;
        if (state_nxt == ST_P1_INT) i_r <= order_r + 5'd1;
      end
      ST_SQRT: begin
        if (!sq_try[64]) sv_r <= sq_try[63:0];
        sres_r <= sq_res_nxt;
        sbit_r <= sbit_r >> 2;
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd31) s_r <= sq_res_nxt[31:0];
      end
      ST_SEED_INT: begin acc_r <= mres[63:0]; sat_r <= sat_r | mres[64]; end
      ST_SEED_S: begin
        pmm_r <= mres[63:0];
        acc_r <= mres[63:0];
        sat_r <= sat_r | mres[64];
        i_r <= (i_r == order_r) ? order_r + 5'd1 : i_r + 5'd1;
      end
      ST_P1_INT: begin acc_r <= mres[63:0]; sat_r <= sat_r | mres[64]; end
      ST_P1_X: begin
        pm1_r <= mres[63:0];
        acc_r <= mres[63:0];
        sat_r <= sat_r | mres[64];
        i_r <= order_r + 5'd2;
      end
      ST_T_INT: begin acc_r <= mres[63:0]; sat_r <= sat_r | mres[64]; end
      ST_T_X:   begin acc_r <= mres[63:0]; sat_r <= sat_r | mres[64]; end
      ST_U_INT: begin u_r <= mres[63:0]; sat_r <= sat_r | mres[64]; end
      ST_SUB: begin
        sat_r  <= sat_r | subr[64];
        qneg_r <= subr[63];
        qmag_r <= mag(subr[63:0]);
        sv_r   <= 64'd0;
        cnt_r  <= 7'd0;
      end
      ST_DIV: begin
        if (cnt_r != 7'd64) begin
          // restoring divide, one quotient bit a cycle
          if (!div_try[64]) begin
            sv_r <= div_try[63:0];
            qmag_r <= {qmag_r[62:0], 1'b1};
          end else begin
            sv_r <= div_rem_sh;
            qmag_r <= {qmag_r[62:0], 1'b0};
          end
          cnt_r <= cnt_r + 7'd1;
        end else begin
          acc_r <= dres[63:0];
          sat_r <= sat_r | dres[64];
          pmm_r <= pm1_r;
          pm1_r <= dres[63:0];
          i_r <= i_r + 5'd1;
        end
      end
      ST_OUT: if (!ovalid_r || out_tready) begin
        res_r   <= (stat_r == STAT_BAD) ? 64'd0 : acc_r;
        ostat_r <= (stat_r == STAT_BAD) ? STAT_BAD : (sat_r ? STAT_SAT : STAT_OK);
      end
      default: ;
    endcase
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = res_r;
  assign out_tuser  = ostat_r;

  `ALE_ASSERT_IMP(a_busy_not_ready, state_r != ST_IDLE, !in_tready)
  `ALE_ASSERT_NXT(a_out_after_seq, state_r == ST_OUT, out_tvalid)
  `ALE_ASSERT_IMP(a_bad_zero, out_tvalid && out_tuser == STAT_BAD, out_tdata == 64'd0)
endmodule
